// ===== design/entropy_information_gain_macros.svh =====
// ----------------------------------------------------------------------------
// Entropy / information gain assertion macros
// Short forms for clocked assertions with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef ENTROPY_INFORMATION_GAIN_MACROS_SVH
`define ENTROPY_INFORMATION_GAIN_MACROS_SVH

// consequent must hold on the cycle after the antecedent
`define EIG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// consequent must hold on the same cycle as the antecedent
`define EIG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== design/eig_pkg.sv =====
// ----------------------------------------------------------------------------
// eig_pkg
// Shared constants for the entropy / information gain block.
// ----------------------------------------------------------------------------
package eig_pkg;

	localparam int RES_W = 24;
	localparam logic [RES_W-1:0] RES_MAX = {RES_W{1'b1}};
	localparam int CNT_OUT_W = 9;

	// accumulator targets of the shared c*lg(c) unit
	typedef logic [1:0] acc_sel_t;
	localparam acc_sel_t SEL_NEG_L = 2'd0;
	localparam acc_sel_t SEL_POS_C = 2'd1;
	localparam acc_sel_t SEL_NEG_C = 2'd2;
	localparam acc_sel_t SEL_POS_L = 2'd3;

endpackage

// ===== design/entropy_information_gain.sv =====
// Items without last are taken one per cycle while the block is idle. A last item starts a pass
// that scans the sample store once per sample, runs the shared squaring log unit once per
// distinct label, attribute and pair class and once for n itself, then does two restoring
// divides and a set-up and an output step.
// Throughput is set by the single read port of the sample store and the one log unit.
// Reset (arst_n low, async) clears the sample count, overflow flag and result valid.
// ----------------------------------------------------------------------------
// entropy_information_gain
// Buffers a batch of samples and returns label entropy and attribute gain.
// ----------------------------------------------------------------------------
module entropy_information_gain #(
	parameter int MAX_SAMPLES = 256,
	parameter int FRAC_BITS   = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [31:0]                   label_key,
	input  logic [31:0]                   attr_key,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [eig_pkg::RES_W-1:0]     label_entropy,
	output logic [eig_pkg::RES_W-1:0]     info_gain,
	output logic [eig_pkg::CNT_OUT_W-1:0] sample_count,
	output logic                          overflowed
);

	localparam int AW  = $clog2(MAX_SAMPLES);
	localparam int CW  = $clog2(MAX_SAMPLES + 1);
	localparam int LGW = CW + FRAC_BITS;
	localparam int SW  = CW + LGW + 1;
	localparam int FCW = $clog2(FRAC_BITS + 1);
	localparam int DCW = $clog2(SW + 1);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RDI   = 4'd1;
	localparam logic [3:0] ST_LATCH = 4'd2;
	localparam logic [3:0] ST_SCAN  = 4'd3;
	localparam logic [3:0] ST_DRAIN = 4'd4;
	localparam logic [3:0] ST_PICK  = 4'd5;
	localparam logic [3:0] ST_LGSQ  = 4'd6;
	localparam logic [3:0] ST_MUL   = 4'd7;
	localparam logic [3:0] ST_ACC   = 4'd8;
	localparam logic [3:0] ST_NEXT  = 4'd9;
	localparam logic [3:0] ST_DSET  = 4'd10;
	localparam logic [3:0] ST_DIV   = 4'd11;
	localparam logic [3:0] ST_OUT   = 4'd12;

	logic [31:0] label_mem [MAX_SAMPLES];
	logic [31:0] attr_mem  [MAX_SAMPLES];
	logic [31:0] rd_label_q, rd_attr_q;
	logic [AW-1:0] raddr;

	logic [3:0]  state_q;
	logic [CW-1:0] fill_q, n_q;
	logic        ovf_q;
	logic [AW-1:0] i_q, j_q, jd_s1;
	logic        v_s1;
	logic [31:0] li_q, ai_q;
	logic        first_l_q, first_a_q, first_p_q;
	logic [CW-1:0] cnt_l_q, cnt_a_q, cnt_p_q;
	eig_pkg::acc_sel_t sel_q;

	logic [CW-1:0] x_q;
	logic [CW-1:0] e_q;
	logic [31:0] m_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic [FCW-1:0] sq_cnt_q;
	logic [SW-1:0] prod_q;
	logic [SW-1:0] neg_l_q, pos_c_q, neg_c_q, pos_l_q;

	logic [SW-1:0] num_q, hl_q;
	logic [CW-1:0] rem_q;
	logic [DCW-1:0] div_cnt_q;
	logic        div_ph_q;

	logic        out_valid_q, ovf_out_q;
	logic [eig_pkg::RES_W-1:0] ent_q, gain_q;
	logic [CW-1:0] cnt_out_q;

	logic        accept, full, out_load;
	logic [CW-1:0] x_sel, e_sel;
	logic        pick_first;
	logic [32:0] sq_t;
	logic [CW:0] rem_sh, rem_sub;
	logic        ge;
	logic [SW-1:0] quot;
	logic        eq_l, eq_a, before_i;
	logic [SW-1:0] gain_raw;

	function automatic logic [eig_pkg::RES_W-1:0] sat24(input logic [SW-1:0] v);
		if (64'(v) > 64'(eig_pkg::RES_MAX))
			return eig_pkg::RES_MAX;
		return eig_pkg::RES_W'(v);
	endfunction

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign full     = (fill_q == CW'(MAX_SAMPLES));
	assign raddr    = (state_q == ST_RDI) ? i_q : j_q;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk) begin
		if (accept && !full) begin
			label_mem[fill_q[AW-1:0]] <= label_key;
			attr_mem[fill_q[AW-1:0]]  <= attr_key;
		end
		rd_label_q <= label_mem[raddr];
		rd_attr_q  <= attr_mem[raddr];
	end

	always_comb begin
		case (sel_q)
			eig_pkg::SEL_NEG_L: begin
				x_sel      = cnt_l_q;
				pick_first = first_l_q;
			end
			eig_pkg::SEL_POS_C: begin
				x_sel      = cnt_a_q;
				pick_first = first_a_q;
			end
			eig_pkg::SEL_NEG_C: begin
				x_sel      = cnt_p_q;
				pick_first = first_p_q;
			end
			default: begin
				x_sel      = n_q;
				pick_first = 1'b1;
			end
		endcase
		e_sel = '0;
		for (int k = 0; k < CW; k++)
			if (x_sel[k]) e_sel = CW'(k);
	end

	assign sq_t = 33'((64'(m_q) * 64'(m_q)) >> 31);

	assign rem_sh  = {rem_q, num_q[SW-1]};
	assign ge      = (rem_sh >= {1'b0, n_q});
	assign rem_sub = ge ? (rem_sh - {1'b0, n_q}) : rem_sh;
	assign quot    = {num_q[SW-2:0], ge};
	assign gain_raw = (hl_q > num_q) ? (hl_q - num_q) : '0;

	assign eq_l     = (rd_label_q == li_q);
	assign eq_a     = (rd_attr_q == ai_q);
	assign before_i = (jd_s1 < i_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			n_q         <= '0;
			ovf_q       <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			jd_s1       <= '0;
			v_s1        <= 1'b0;
			li_q        <= '0;
			ai_q        <= '0;
			first_l_q   <= 1'b0;
			first_a_q   <= 1'b0;
			first_p_q   <= 1'b0;
			cnt_l_q     <= '0;
			cnt_a_q     <= '0;
			cnt_p_q     <= '0;
			sel_q       <= eig_pkg::SEL_NEG_L;
			x_q         <= '0;
			e_q         <= '0;
			m_q         <= '0;
			frac_q      <= '0;
			sq_cnt_q    <= '0;
			prod_q      <= '0;
			neg_l_q     <= '0;
			pos_c_q     <= '0;
			neg_c_q     <= '0;
			pos_l_q     <= '0;
			num_q       <= '0;
			hl_q        <= '0;
			rem_q       <= '0;
			div_cnt_q   <= '0;
			div_ph_q    <= 1'b0;
			out_valid_q <= 1'b0;
			ovf_out_q   <= 1'b0;
			ent_q       <= '0;
			gain_q      <= '0;
			cnt_out_q   <= '0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			// compare stage: data of sample jd_s1 against sample i
			v_s1 <= (state_q == ST_SCAN);
			if (v_s1) begin
				if (before_i) begin
					if (eq_l)         first_l_q <= 1'b0;
					if (eq_a)         first_a_q <= 1'b0;
					if (eq_l && eq_a) first_p_q <= 1'b0;
				end else begin
					if (eq_l)         cnt_l_q <= cnt_l_q + 1'b1;
					if (eq_a)         cnt_a_q <= cnt_a_q + 1'b1;
					if (eq_l && eq_a) cnt_p_q <= cnt_p_q + 1'b1;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (full)
							ovf_q <= 1'b1;
						else
							fill_q <= fill_q + 1'b1;
						if (last) begin
							n_q     <= full ? fill_q : fill_q + 1'b1;
							i_q     <= '0;
							neg_l_q <= '0;
							pos_c_q <= '0;
							neg_c_q <= '0;
							state_q <= ST_RDI;
						end
					end
				end
				ST_RDI: state_q <= ST_LATCH;
				ST_LATCH: begin
					li_q      <= rd_label_q;
					ai_q      <= rd_attr_q;
					first_l_q <= 1'b1;
					first_a_q <= 1'b1;
					first_p_q <= 1'b1;
					cnt_l_q   <= '0;
					cnt_a_q   <= '0;
					cnt_p_q   <= '0;
					j_q       <= '0;
					state_q   <= ST_SCAN;
				end
				ST_SCAN: begin
					jd_s1 <= j_q;
					if (CW'(j_q) == n_q - 1'b1)
						state_q <= ST_DRAIN;
					else
						j_q <= j_q + 1'b1;
				end
				ST_DRAIN: begin
					sel_q   <= eig_pkg::SEL_NEG_L;
					state_q <= ST_PICK;
				end
				ST_PICK: begin
					if (pick_first) begin
						x_q      <= x_sel;
						e_q      <= e_sel;
						m_q      <= 32'(x_sel) << (5'd31 - 5'(e_sel));
						frac_q   <= '0;
						sq_cnt_q <= '0;
						state_q  <= ST_LGSQ;
					end else if (sel_q == eig_pkg::SEL_NEG_C) begin
						state_q <= ST_NEXT;
					end else begin
						sel_q <= sel_q + 1'b1;
					end
				end
				ST_LGSQ: begin
					// mantissa squared; a value of two or more gives a one bit
					if (sq_t[32]) begin
						m_q    <= sq_t[32:1];
						frac_q <= {frac_q[FRAC_BITS-2:0], 1'b1};
					end else begin
						m_q    <= sq_t[31:0];
						frac_q <= {frac_q[FRAC_BITS-2:0], 1'b0};
					end
					sq_cnt_q <= sq_cnt_q + 1'b1;
					if (sq_cnt_q == FCW'(FRAC_BITS - 1))
						state_q <= ST_MUL;
				end
				ST_MUL: begin
					prod_q  <= SW'(x_q) * SW'({e_q, frac_q});
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					case (sel_q)
						eig_pkg::SEL_NEG_L: neg_l_q <= neg_l_q + prod_q;
						eig_pkg::SEL_POS_C: pos_c_q <= pos_c_q + prod_q;
						eig_pkg::SEL_NEG_C: neg_c_q <= neg_c_q + prod_q;
						default:            pos_l_q <= prod_q;
					endcase
					if (sel_q == eig_pkg::SEL_POS_L) begin
						state_q <= ST_DSET;
					end else if (sel_q == eig_pkg::SEL_NEG_C) begin
						state_q <= ST_NEXT;
					end else begin
						sel_q   <= sel_q + 1'b1;
						state_q <= ST_PICK;
					end
				end
				ST_NEXT: begin
					if (CW'(i_q) == n_q - 1'b1) begin
						sel_q   <= eig_pkg::SEL_POS_L;
						state_q <= ST_PICK;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_RDI;
					end
				end
				ST_DSET: begin
					num_q     <= (pos_l_q > neg_l_q) ? (pos_l_q - neg_l_q) : '0;
					rem_q     <= '0;
					div_cnt_q <= '0;
					div_ph_q  <= 1'b0;
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					if (div_cnt_q == DCW'(SW - 1)) begin
						if (!div_ph_q) begin
							hl_q      <= quot;
							num_q     <= (pos_c_q > neg_c_q) ? (pos_c_q - neg_c_q) : '0;
							rem_q     <= '0;
							div_cnt_q <= '0;
							div_ph_q  <= 1'b1;
						end else begin
							// num_q keeps the conditional entropy
							num_q   <= quot;
							state_q <= ST_OUT;
						end
					end else begin
						num_q     <= quot;
						rem_q     <= rem_sub[CW-1:0];
						div_cnt_q <= div_cnt_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						ent_q       <= sat24(hl_q);
						gain_q      <= sat24(gain_raw);
						cnt_out_q   <= n_q;
						ovf_out_q   <= ovf_q;
						fill_q      <= '0;
						ovf_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign label_entropy = ent_q;
	assign info_gain     = gain_q;
	assign sample_count  = eig_pkg::CNT_OUT_W'(cnt_out_q);
	assign overflowed    = ovf_out_q;

endmodule

// ===== design/eig_checker.sv =====
// ----------------------------------------------------------------------------
// eig_checker
// Port-level checks on the entropy / information gain block.
// ----------------------------------------------------------------------------
`include "entropy_information_gain_macros.svh"

module eig_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      last,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [eig_pkg::RES_W-1:0] label_entropy,
	input logic [eig_pkg::RES_W-1:0] info_gain
);

	`EIG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(label_entropy) && $stable(info_gain), "stalled result changed")
	`EIG_ASSERT_NOW(a_gain_le_ent, out_valid, info_gain <= label_entropy, "gain above entropy")
	`EIG_ASSERT_NEXT(a_busy_after_last, in_valid && !in_stall && last, in_stall, "not busy after last item")
	`EIG_ASSERT_NOW(a_result_after_busy, $rose(out_valid), $past(in_stall), "result without a pass")

endmodule

bind entropy_information_gain eig_checker u_eig_checker (.*);
